// File: hw/rtl/tirt_pkg.sv
// Package for the transaction id ring table.
// Holds the record type shared by the storage cells and the top level.
// No dependencies.
package tirt_pkg;

    // Width of the reported slot number, fixed by the result format.
    localparam int unsigned FOUND_INDEX_W = 6;
    localparam int unsigned WORD_W        = 32;

    // One stored transaction record. A record that is not valid matches only key zero and reports zero fields.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] trans_id;
        logic [WORD_W-1:0] program_number;
        logic [WORD_W-1:0] version_number;
        logic [WORD_W-1:0] procedure_number;
        logic [WORD_W-1:0] handle;
    } t_entry;

endpackage

// File: hw/rtl/transaction_id_ring_table.sv
// Transaction id ring table: a ring of record cells that rotates past a single comparator.
// Enter requests are taken one per cycle while no find is in progress and complete in that cycle, with no result.
// A find request holds the input while the ring makes one full turn past the comparator
// and then while the result is handed over to the output register.
// A result still held on the output delays the hand-over until it is taken.
// Synchronous active-low reset clears the valid bit of every cell, so all records count as empty.
// Depends on tirt_pkg and tirt_cell.
module transaction_id_ring_table #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_trans_id,
    input  logic [31:0] i_program_number,
    input  logic [31:0] i_version_number,
    input  logic [31:0] i_procedure_number,
    input  logic [31:0] i_handle_in,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [tirt_pkg::FOUND_INDEX_W-1:0] o_found_index,
    output logic [31:0] o_found_program,
    output logic [31:0] o_found_version,
    output logic [31:0] o_found_procedure,
    output logic [31:0] o_found_handle
);
    import tirt_pkg::*;

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] SLOT_COUNT = IDX_W'(ENTRIES);

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [IDX_W-1:0] r_write_ptr;
    logic [IDX_W-1:0] r_hint;
    logic [IDX_W-1:0] r_step;
    logic [31:0]      r_key;

    // Best match seen so far in this scan, ranked by circular distance from the hint.
    logic             r_found;
    logic [IDX_W-1:0] r_best_dist;
    logic [IDX_W-1:0] r_best_slot;
    t_entry           r_best;

    logic             r_out_valid;

    logic   req_accept;
    logic   enter_accept;
    logic   find_accept;
    logic   ring_shift;
    logic   out_free;
    t_entry load_entry;
    t_entry cell_q [ENTRIES];

    logic             head_match;
    logic [IDX_W-1:0] head_dist;
    logic             take_head;
    logic [IDX_W+FOUND_INDEX_W-1:0] slot_ext;

    assign o_stall      = (r_state != ST_IDLE);
    assign req_accept   = i_valid && !o_stall;
    assign enter_accept = req_accept && !i_mode;
    assign find_accept  = req_accept && i_mode;
    assign ring_shift   = (r_state == ST_SCAN);
    assign out_free     = !r_out_valid || !i_stall;

    always_comb begin
        load_entry                  = '0;
        load_entry.valid            = 1'b1;
        load_entry.trans_id         = i_trans_id;
        load_entry.program_number   = i_program_number;
        load_entry.version_number   = i_version_number;
        load_entry.procedure_number = i_procedure_number;
        load_entry.handle           = i_handle_in;
    end

    // The ring: cell i takes its record from cell i+1, and the last cell from cell 0.
    // One full turn brings every record back home, so between scans cell i holds slot i
    // and during a scan cell 0 holds slot r_step.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        localparam int unsigned NEXT = (g + 1) % ENTRIES;
        tirt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (ring_shift),
            .i_load       (enter_accept && (r_write_ptr == IDX_W'(g))),
            .i_load_entry (load_entry),
            .i_prev       (cell_q[NEXT]),
            .o_entry      (cell_q[g])
        );
    end

    // An empty cell counts as id zero, so only the key zero can match it.
    assign head_match = cell_q[0].valid ? (cell_q[0].trans_id == r_key) : (r_key == '0);

    // Circular distance of the current slot from the hint.
    always_comb begin
        head_dist = r_step - r_hint;
        if (r_step < r_hint) begin
            head_dist = r_step - r_hint + SLOT_COUNT;
        end
    end

    assign take_head = ring_shift && head_match && (!r_found || (head_dist < r_best_dist));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (find_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_step == LAST_SLOT) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_write_ptr <= '0;
            r_hint      <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (enter_accept) begin
                r_write_ptr <= (r_write_ptr == LAST_SLOT) ? '0 : r_write_ptr + 1'b1;
            end
            if (find_accept) begin
                r_step  <= '0;
                r_found <= 1'b0;
            end else if (ring_shift) begin
                r_step <= r_step + 1'b1;
                if (take_head) begin
                    r_found <= 1'b1;
                end
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                if (r_found) begin
                    r_hint <= r_best_slot;
                end
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (find_accept) begin
            r_key <= i_trans_id;
        end
        if (take_head) begin
            r_best_dist <= head_dist;
            r_best_slot <= r_step;
            r_best      <= cell_q[0];
        end
    end

    // Result register; a miss reports all zero fields.
    assign slot_ext = {{FOUND_INDEX_W{1'b0}}, r_best_slot};

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            o_hit <= r_found;
            if (r_found && r_best.valid) begin
                o_found_program   <= r_best.program_number;
                o_found_version   <= r_best.version_number;
                o_found_procedure <= r_best.procedure_number;
                o_found_handle    <= r_best.handle;
            end else begin
                o_found_program   <= '0;
                o_found_version   <= '0;
                o_found_procedure <= '0;
                o_found_handle    <= '0;
            end
            o_found_index <= r_found ? slot_ext[FOUND_INDEX_W-1:0] : '0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: hw/rtl/tirt_cell.sv
// One storage cell of the transaction id ring table.
// Holds a single record and takes its neighbor's record when the ring rotates.
// Depends on tirt_pkg.
module tirt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_load,
    input  tirt_pkg::t_entry i_load_entry,
    input  tirt_pkg::t_entry i_prev,
    output tirt_pkg::t_entry o_entry
);
    import tirt_pkg::*;

    logic   r_valid;
    t_entry r_data;

    // Only the valid bit is cleared by reset; the payload is passed through unchanged while invalid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_entry;
        end else if (i_shift) begin
            r_data <= i_prev;
        end
    end

    always_comb begin
        o_entry       = r_data;
        o_entry.valid = r_valid;
    end

endmodule

// File: hw/rtl/tirt_checker.sv
// Port-level checker for the transaction id ring table, with its bind statement.
// Watches only the top level's ports. Depends on transaction_id_ring_table.
module tirt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_mode,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_hit,
    input logic [5:0]  o_found_index,
    input logic [31:0] o_found_program,
    input logic [31:0] o_found_version,
    input logic [31:0] o_found_procedure,
    input logic [31:0] o_found_handle
);

    // A held result keeps its hit flag, slot index and handle until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_found_index)
            && $stable(o_found_handle))
        else $error("held result changed");

    // A miss reports zero in every field.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_found_index == 6'd0 && o_found_program == 32'd0
            && o_found_version == 32'd0 && o_found_procedure == 32'd0
            && o_found_handle == 32'd0)
        else $error("miss with nonzero fields");

    // A find request blocks further requests while the ring turns.
    a_find_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_mode |=> o_stall)
        else $error("find request did not start a scan");

    // An enter request completes at once.
    a_enter_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_mode |=> !o_stall)
        else $error("enter request stalled the input");

    // A new result only follows a scan.
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a scan");

endmodule

bind transaction_id_ring_table tirt_checker u_tirt_checker (.*);

// File: tb/transaction_id_ring_table_tb.sv
// Self-checking testbench for transaction_id_ring_table: directed and random enter/find traffic.
// A small class mirrors the record ring and checks every lookup result in order.
// Depends on tirt_pkg and the transaction_id_ring_table RTL.
module transaction_id_ring_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH    = 64;
    localparam int unsigned CLK_PERIOD     = 4;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned RANDOM_ITEMS   = 530;
    localparam int unsigned IDLE_PERCENT   = 21;
    // The receiver hold-off has to outlast a full find scan by a wide margin so that
    // a finished lookup sits in the output stage and the next find backs up the input.
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned ID_POOL_SIZE   = 12;
    localparam int unsigned PRINT_LIMIT    = 40;

    // Request opcodes carried on i_mode.
    localparam logic MODE_ENTER = 1'b0;
    localparam logic MODE_FIND  = 1'b1;

    localparam int unsigned WW = tirt_pkg::WORD_W;
    localparam int unsigned IW = tirt_pkg::FOUND_INDEX_W;

    // One transaction record as it is written by an enter request.
    typedef struct packed {
        logic [WW-1:0] trans_id;
        logic [WW-1:0] prog_no;
        logic [WW-1:0] vers_no;
        logic [WW-1:0] proc_no;
        logic [WW-1:0] handle;
    } t_record;

    typedef struct packed {
        logic    mode;
        t_record rec;
    } t_request;

    // What a find request reports: all zero on a miss.
    typedef struct packed {
        logic          hit;
        logic [IW-1:0] slot;
        logic [WW-1:0] prog_no;
        logic [WW-1:0] vers_no;
        logic [WW-1:0] proc_no;
        logic [WW-1:0] handle;
    } t_lookup;

    // Mirror of the record ring plus the queue of lookups still owed by the block.
    class ring_table_mirror #(int unsigned DEPTH = 64);
        t_record     slots[DEPTH];
        int unsigned write_slot;
        int unsigned search_slot;
        t_lookup     pending_lookups[$];
        int unsigned mismatch_count;

        function new();
            foreach (slots[i]) slots[i] = '0;
            write_slot     = 0;
            search_slot    = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned pending();
            return pending_lookups.size();
        endfunction

        // Update the mirror with one accepted request; a find queues its lookup.
        function void apply_request(t_request req);
            t_lookup     res;
            int unsigned s;
            int unsigned n;
            bit          found;
            res   = '0;
            found = 1'b0;
            if (req.mode == MODE_ENTER) begin
                slots[write_slot] = req.rec;
                write_slot = (write_slot + 1) % DEPTH;
            end else begin
                s = search_slot;
                for (n = 0; n < DEPTH && !found; n++) begin
                    if (slots[s].trans_id == req.rec.trans_id) begin
                        found       = 1'b1;
                        search_slot = s;
                        res.hit     = 1'b1;
                        res.slot    = s[IW-1:0];
                        res.prog_no = slots[s].prog_no;
                        res.vers_no = slots[s].vers_no;
                        res.proc_no = slots[s].proc_no;
                        res.handle  = slots[s].handle;
                    end else begin
                        s = (s + 1) % DEPTH;
                    end
                end
                pending_lookups.push_back(res);
            end
        endfunction

        task report_mismatch(string what, logic [WW-1:0] got, logic [WW-1:0] want);
            if (mismatch_count < PRINT_LIMIT) begin
                $display("%0t ns: lookup error, %s: got %h, want %h", $time, what, got, want);
            end
            mismatch_count++;
        endtask

        // Compare one lookup from the block with the oldest one owed.
        task compare_lookup(t_lookup got);
            t_lookup want;
            if (pending_lookups.size() == 0) begin
                report_mismatch("result with no find outstanding", WW'(got.hit), '0);
            end else begin
                want = pending_lookups.pop_front();
                if (got.hit !== want.hit) report_mismatch("hit", WW'(got.hit), WW'(want.hit));
                if (got.slot !== want.slot) report_mismatch("found_index", WW'(got.slot),
                    WW'(want.slot));
                if (got.prog_no !== want.prog_no) report_mismatch("found_program",
                    got.prog_no, want.prog_no);
                if (got.vers_no !== want.vers_no) report_mismatch("found_version",
                    got.vers_no, want.vers_no);
                if (got.proc_no !== want.proc_no) report_mismatch("found_procedure",
                    got.proc_no, want.proc_no);
                if (got.handle !== want.handle) report_mismatch("found_handle",
                    got.handle, want.handle);
            end
        endtask
    endclass

    // Every input of the block starts at a known value, reset asserted.
    logic          i_clk              = 1'b0;
    logic          i_rst_n            = 1'b0;
    logic          i_valid            = 1'b0;
    logic          i_mode             = MODE_ENTER;
    logic [31:0]   i_trans_id         = '0;
    logic [31:0]   i_program_number   = '0;
    logic [31:0]   i_version_number   = '0;
    logic [31:0]   i_procedure_number = '0;
    logic [31:0]   i_handle_in        = '0;
    logic          i_stall            = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic          o_hit;
    logic [IW-1:0] o_found_index;
    logic [31:0]   o_found_program;
    logic [31:0]   o_found_version;
    logic [31:0]   o_found_procedure;
    logic [31:0]   o_found_handle;

    // Flags shared between the request driver and the result-side stall driver.
    bit            steady_phase = 1'b0;  // no idling on either side while set
    bit            hold_pending = 1'b0;  // asks the result side for one long hold-off

    logic [31:0]   id_pool[ID_POOL_SIZE];

    ring_table_mirror #(TABLE_DEPTH) table_mirror;

    transaction_id_ring_table #(
        .ENTRIES(TABLE_DEPTH)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_mode             (i_mode),
        .i_trans_id         (i_trans_id),
        .i_program_number   (i_program_number),
        .i_version_number   (i_version_number),
        .i_procedure_number (i_procedure_number),
        .i_handle_in        (i_handle_in),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_hit              (o_hit),
        .o_found_index      (o_found_index),
        .o_found_program    (o_found_program),
        .o_found_version    (o_found_version),
        .o_found_procedure  (o_found_procedure),
        .o_found_handle     (o_found_handle)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // Decides whether the request side or the result side sits out the coming cycle.
    function automatic bit take_gap();
        return !steady_phase && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Offers one request at a falling edge and holds it until the block takes it at a
    // rising edge with o_stall low. Random idle cycles come first. The payload is never
    // touched while the request waits, and i_valid gets a single assignment per edge.
    task automatic send_request(t_request req);
        while (take_gap()) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid            <= 1'b1;
        i_mode             <= req.mode;
        i_trans_id         <= req.rec.trans_id;
        i_program_number   <= req.rec.prog_no;
        i_version_number   <= req.rec.vers_no;
        i_procedure_number <= req.rec.proc_no;
        i_handle_in        <= req.rec.handle;
        do @(posedge i_clk); while (o_stall);
        table_mirror.apply_request(req);
    endtask

    // Drops i_valid at the next falling edge, so the request just taken is not seen twice
    // while the driver waits on something other than the handshake.
    task automatic release_request();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic enter_record(logic [31:0] id, logic [31:0] prog, logic [31:0] vers,
                                logic [31:0] proc_no, logic [31:0] handle);
        t_request req;
        req.mode = MODE_ENTER;
        req.rec  = {id, prog, vers, proc_no, handle};
        send_request(req);
    endtask

    // A find carries random payload on the fields it ignores.
    task automatic find_record(logic [31:0] id);
        t_request req;
        req.mode = MODE_FIND;
        req.rec  = {id, $urandom(), $urandom(), $urandom(), $urandom()};
        send_request(req);
    endtask

    // Random traffic: somewhat more finds than enters, and ids mostly from a small pool
    // so that finds hit often, hit duplicates, and the ring wraps several times over.
    function automatic t_request random_request();
        t_request req;
        req.mode = ($urandom_range(99) < 45) ? MODE_ENTER : MODE_FIND;
        req.rec.trans_id = ($urandom_range(99) < 65) ?
            id_pool[$urandom_range(ID_POOL_SIZE - 1)] : $urandom();
        req.rec.prog_no  = $urandom();
        req.rec.vers_no  = $urandom();
        req.rec.proc_no  = $urandom();
        req.rec.handle   = $urandom();
        return req;
    endfunction

    // Result side: random stalls, one long hold-off on request, none in the steady phase.
    // The hold-off is counted here so the request driver keeps offering work meanwhile.
    initial begin : result_stall_driver
        int unsigned hold_left;
        logic        next_stall;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                next_stall = 1'b1;
                hold_left--;
            end else begin
                next_stall = take_gap();
            end
            i_stall <= next_stall;
        end
    end

    // Every result taken by the result side is checked against the oldest pending find.
    always @(posedge i_clk) begin : result_monitor
        t_lookup got;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got.hit     = o_hit;
            got.slot    = o_found_index;
            got.prog_no = o_found_program;
            got.vers_no = o_found_version;
            got.proc_no = o_found_procedure;
            got.handle  = o_found_handle;
            table_mirror.compare_lookup(got);
        end
    end

    // Ends the run if neither channel moves for too long. The longest legal quiet stretch
    // is the receiver hold-off plus one find scan plus random stalls, well under the limit.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("transaction_id_ring_table: mismatch");
        $finish;
    end

    initial begin : request_driver
        t_request    req;
        int unsigned item;
        table_mirror = new();

        // The pool always holds id zero and the all-ones id beside random ids.
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (item = 2; item < ID_POOL_SIZE; item++) id_pool[item] = $urandom();

        // Synchronous reset, held for a fixed number of cycles and released at a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. An empty table holds id zero everywhere, so finding zero hits
        // slot 0 with zero fields, while an id that was never written misses.
        find_record('0);
        find_record('1);
        // Extremes of every stored field; the all-ones record lands in slot 0.
        enter_record('1, '1, '1, '1, '1);
        find_record('1);
        // Slot 0 no longer holds zero, so a zero lookup now moves on to slot 1.
        find_record('0);
        // A real record whose id is zero, in slot 1, found with its payload.
        enter_record('0, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'h0000_0001, 32'h8000_0000);
        find_record('0);
        // Duplicate ids: slots 2 and 4 share an id, slot 3 sits between them. Once the
        // hint moves to slot 3, the first match in circular order is slot 4, not slot 2.
        enter_record(32'h0000_1234, 32'h1, 32'h2, 32'h3, 32'h4);
        enter_record(32'h0000_5678, 32'h5, 32'h6, 32'h7, 32'h8);
        enter_record(32'h0000_1234, 32'h9, 32'ha, 32'hb, 32'hc);
        find_record(32'h0000_1234);
        find_record(32'h0000_5678);
        find_record(32'h0000_1234);
        find_record(32'h0000_1234);
        // A record of all zeros next to single-bit ids.
        enter_record('0, '0, '0, '0, '0);
        enter_record(32'h0000_0001, '1, '0, '1, '0);
        enter_record(32'h8000_0000, '0, '1, '0, '1);
        find_record(32'h8000_0000);
        find_record(32'h0000_0001);
        // The hint now sits at slot 6: a zero lookup hits the first empty slot after it, slot 8.
        find_record('0);
        find_record(32'hdead_beef);

        // Random part, with one receiver hold-off, one full drain and one steady stretch.
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            if (item == 150) hold_pending = 1'b1;
            if (item == 330) begin
                // Sender pause: nothing new until every find has reported.
                release_request();
                while (table_mirror.pending() != 0) @(posedge i_clk);
            end
            steady_phase = (item >= 420 && item < 500);
            req = random_request();
            send_request(req);
        end
        steady_phase = 1'b0;
        release_request();

        // Wait for the outstanding finds, then keep the clock running so stray results would still be seen.
        while (table_mirror.pending() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        if (table_mirror.mismatch_count == 0) begin
            $display("transaction_id_ring_table: match");
        end else begin
            $display("transaction_id_ring_table: mismatch");
        end
        $finish;
    end

endmodule
